// File: rtl/core/port_id_map_table_defines.svh
// assertion macros for the port id map table
// needs clk and rst_n in the scope where a macro is used
`ifndef PORT_ID_MAP_TABLE_DEFINES_SVH
`define PORT_ID_MAP_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PIDM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("port id map table: same-cycle check failed");

// next-cycle implication, checked outside reset
`define PIDM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("port id map table: next-cycle check failed");

`endif

// File: rtl/core/pidm_pkg.sv
// shared types and constants of the port id map table
// no dependencies
package pidm_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int KIND_W = 2;
  localparam int KEY_W  = 16;
  localparam int VAL_W  = 16;
  localparam int ST_W   = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  // sequencer to cell row
  typedef struct packed {
    logic             shift_en;
    logic             load_en;
    logic [IDX_W-1:0] load_idx;
    entry_t           load_entry;
  } cell_ctl_t;

endpackage

// File: rtl/core/pidm_cell.sv
// one table entry of the rotating cell row
// depends on pidm_pkg
module pidm_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  logic            load_en,
  input  pidm_pkg::entry_t shift_in,
  input  pidm_pkg::entry_t load_in,
  output pidm_pkg::entry_t entry_o
);
  import pidm_pkg::*;

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (load_en) begin
      valid_nxt = load_in.valid;
      key_nxt   = load_in.key;
      value_nxt = load_in.value;
    end else if (shift_en) begin
      valid_nxt = shift_in.valid;
      key_nxt   = shift_in.key;
      value_nxt = shift_in.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign entry_o = '{valid: valid_r, key: key_r, value: value_r};

endmodule

// File: rtl/core/pidm_ctrl.sv
// sequencer: takes a beat, walks the rotating row once, answers
// depends on pidm_pkg
module pidm_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pidm_pkg::KIND_W-1:0] in_kind,
  input  logic [pidm_pkg::KEY_W-1:0]  in_vport_key,
  input  logic [pidm_pkg::VAL_W-1:0]  in_port_number,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pidm_pkg::ST_W-1:0]   out_status,
  output logic [pidm_pkg::VAL_W-1:0]  out_found_port_number,
  input  pidm_pkg::entry_t            head_i,
  output pidm_pkg::entry_t            tail_o,
  output pidm_pkg::cell_ctl_t         ctl_o
);
  import pidm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic              hit_r, hit_nxt;
  logic              free_seen_r, free_seen_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic [VAL_W-1:0]  found_r, found_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;
  logic [VAL_W-1:0]  out_found_r, out_found_nxt;

  logic            in_fire;
  logic            head_match;
  logic            out_free;
  logic [ST_W-1:0] status_c;
  entry_t          tail_c;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // first valid entry with the key, seen at the head of the row
  assign head_match = head_i.valid && (head_i.key == key_r) && !hit_r;

  always_comb begin
    tail_c = head_i;
    if (head_match) begin
      if (kind_r == KIND_INSERT) begin
        tail_c.value = val_r;
      end else if (kind_r == KIND_REMOVE) begin
        tail_c = '0;
      end
    end
  end

  always_comb begin
    status_c = ST_OK;
    if (kind_r == KIND_INSERT) begin
      if (!hit_r && !free_seen_r) begin
        status_c = ST_FULL;
      end
    end else if (kind_r inside {KIND_REMOVE, KIND_LOOKUP}) begin
      if (!hit_r) begin
        status_c = ST_NOT_FOUND;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    hit_nxt        = hit_r;
    free_seen_nxt  = free_seen_r;
    free_idx_nxt   = free_idx_r;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    ctl_o          = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt      = in_kind;
          key_nxt       = in_vport_key;
          val_nxt       = in_port_number;
          cnt_nxt       = '0;
          hit_nxt       = 1'b0;
          free_seen_nxt = 1'b0;
          found_nxt     = '0;
          state_nxt     = S_WALK;
        end
      end
      S_WALK: begin
        ctl_o.shift_en = 1'b1;
        if (head_match) begin
          hit_nxt   = 1'b1;
          found_nxt = head_i.value;
        end
        if (!head_i.valid && !free_seen_r) begin
          free_seen_nxt = 1'b1;
          free_idx_nxt  = cnt_r;
        end
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        // row is back home; a new key lands in the lowest free cell
        if (out_free) begin
          if (kind_r == KIND_INSERT && !hit_r && free_seen_r) begin
            ctl_o.load_en    = 1'b1;
            ctl_o.load_idx   = free_idx_r;
            ctl_o.load_entry = '{valid: 1'b1, key: key_r, value: val_r};
          end
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_c;
          out_found_nxt  = (kind_r == KIND_LOOKUP && hit_r) ? found_r : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      hit_r       <= 1'b0;
      free_seen_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      hit_r       <= hit_nxt;
      free_seen_r <= free_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    free_idx_r   <= free_idx_nxt;
    found_r      <= found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
  end

  assign tail_o                = tail_c;
  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_found_port_number = out_found_r;

endmodule

// File: rtl/core/port_id_map_table.sv
// top level of the port id map table: sequencer plus rotating row of entry cells
// depends on pidm_pkg, pidm_cell, pidm_ctrl and port_id_map_table_defines.svh
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   in_     | input     | in_valid / in_ready  | kind, vport_key, port_number
//   out_    | output    | out_valid / out_ready| status, found_port_number
//
// one beat walks the whole cell row: the row turns once past the head cell,
// one entry per cycle, then a finishing state answers and, for an insert of a
// new key, writes it into the lowest free cell; a waiting result can stall it.
// the result is registered when the finishing state answers.
// reset clears every valid bit at once; no clearing pass.
// a result waiting in the output register holds the finishing cycle only;
// the next input beat is still taken while it waits.
module port_id_map_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pidm_pkg::KIND_W-1:0] in_kind,
  input  logic [pidm_pkg::KEY_W-1:0]  in_vport_key,
  input  logic [pidm_pkg::VAL_W-1:0]  in_port_number,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pidm_pkg::ST_W-1:0]   out_status,
  output logic [pidm_pkg::VAL_W-1:0]  out_found_port_number
);
  import pidm_pkg::*;

  `include "port_id_map_table_defines.svh"

  cell_ctl_t ctl;
  entry_t    tail;
  entry_t    cell_out [TABLE_ENTRIES];

  // sequencer: head of the row is cell 0, tail feeds the last cell
  pidm_ctrl u_ctrl (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_kind               (in_kind),
    .in_vport_key          (in_vport_key),
    .in_port_number        (in_port_number),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_found_port_number (out_found_port_number),
    .head_i                (cell_out[0]),
    .tail_o                (tail),
    .ctl_o                 (ctl)
  );

  // row of cells: each shifts toward cell 0, so entry k sits at the head
  // at walk step k and every entry is home again after a full turn
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    logic   load_hit;
    entry_t from_right;

    assign load_hit = ctl.load_en && (ctl.load_idx == IDX_W'(i));

    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign from_right = tail;
    end else begin : g_mid
      assign from_right = cell_out[i+1];
    end

    pidm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (ctl.shift_en),
      .load_en  (load_hit),
      .shift_in (from_right),
      .load_in  (ctl.load_entry),
      .entry_o  (cell_out[i])
    );
  end

  // a taken beat closes the input until the walk and the answer are over
  `PIDM_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready)
  // the row never rotates while a new entry is written
  `PIDM_ASSERT_NOW(a_no_load_in_walk, ctl.load_en, !ctl.shift_en && !in_ready)
  // only defined status codes leave the block
  `PIDM_ASSERT_NOW(a_status_code, out_valid,
    out_status == ST_OK || out_status == ST_NOT_FOUND || out_status == ST_FULL)
  // a failed operation never carries a port number
  `PIDM_ASSERT_NOW(a_found_zero, out_valid && out_status != ST_OK,
    out_found_port_number == '0)

endmodule
